// ===== rtl/trq_pkg.sv =====
// Package for the two-sided rendezvous queue.
// Holds sizes, status codes, controller states, the command and status structs
// and the ring index helpers. It depends on nothing.
package trq_pkg;

   localparam int QUEUE_DEPTH  = 64;
   localparam int TICKET_WIDTH = 32;
   localparam int OWNER_WIDTH  = 16;
   localparam int TIME_WIDTH   = 48;
   localparam int VALUE_WIDTH  = 64;
   localparam int STATUS_WIDTH = 3;
   localparam int IDX_W        = $clog2(QUEUE_DEPTH);
   localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] SIDE_LEFT  = 2'd1;
   localparam logic [1:0] SIDE_RIGHT = 2'd2;
   localparam logic [1:0] SIDE_BOTH  = SIDE_LEFT | SIDE_RIGHT;

   localparam logic FUNC_ASK    = 1'b0;
   localparam logic FUNC_CANCEL = 1'b1;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_QUEUED    = 3'd0,
      ST_MATCHED   = 3'd1,
      ST_CANCELLED = 3'd2,
      ST_TOO_LATE  = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_RESULT,
      S_REMOVE,
      S_FIX
   } ctl_state_type;

   // one stored waiter
   typedef struct packed {
      logic [TICKET_WIDTH-1:0] ticket;
      logic [VALUE_WIDTH-1:0]  value;
      logic [OWNER_WIDTH-1:0]  owner;
      logic                    stats;
      logic [TIME_WIDTH-1:0]   stamp;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;   // take the request beat
      logic       enqueue;   // write the asker at the tail
      logic       rd_start;  // read the head entry, start a scan there
      logic       rd_next;   // read the next entry of the scan
      logic       rsp_load;  // load the result register
      status_type rsp_kind;  // which result to form
      logic       remove;    // drop the entry last read
      logic       fix_step;  // move head/tail over holes by one
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic func_cancel;
      logic side_ok;
      logic full;
      logic hit;
      logic scan_done;
      logic out_free;
      logic fix_done;
   } dp_stat_type;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_W'(QUEUE_DEPTH - 1) : i - 1'b1;
   endfunction

endpackage

// ===== rtl/trq_datapath.sv =====
// Datapath of the rendezvous queue: request register, waiter memory, live bits,
// ring indices, ticket counter and the result register.
// Depends on trq_pkg; driven by trq_ctrl through ctl_cmd_type.
module trq_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  trq_pkg::ctl_cmd_type             cmd,
   output trq_pkg::dp_stat_type             stat,
   input  logic                             req_func,
   input  logic                             req_side,
   input  logic [trq_pkg::VALUE_WIDTH-1:0]  req_value,
   input  logic [trq_pkg::OWNER_WIDTH-1:0]  req_owner,
   input  logic                             req_with_stats,
   input  logic [trq_pkg::TICKET_WIDTH-1:0] req_cancel_ticket,
   input  logic [trq_pkg::TIME_WIDTH-1:0]   req_now,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [trq_pkg::STATUS_WIDTH-1:0] rsp_status,
   output logic [trq_pkg::TICKET_WIDTH-1:0] rsp_ticket,
   output logic [trq_pkg::VALUE_WIDTH-1:0]  rsp_partner_value,
   output logic [trq_pkg::OWNER_WIDTH-1:0]  rsp_partner_owner,
   output logic                             rsp_partner_stats,
   output logic [trq_pkg::TIME_WIDTH-1:0]   rsp_partner_wait,
   output logic                             rsp_notify_owner
);
   import trq_pkg::*;

   // captured request beat
   logic                    func_ff;
   logic                    side_ff;
   logic [VALUE_WIDTH-1:0]  value_ff;
   logic [OWNER_WIDTH-1:0]  owner_ff;
   logic                    stats_ff;
   logic [TICKET_WIDTH-1:0] cticket_ff;
   logic [TIME_WIDTH-1:0]   now_ff;

   // waiter memory and its read port
   entry_type               mem [QUEUE_DEPTH];
   entry_type               rd_data_ff;
   logic [IDX_W-1:0]        rd_idx_ff;
   logic [IDX_W-1:0]        rd_addr;
   logic                    rd_en;

   // queue control state
   logic [QUEUE_DEPTH-1:0]  live_ff, live_in;
   logic [IDX_W-1:0]        head_ff, head_in;
   logic [IDX_W-1:0]        tail_ff, tail_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [1:0]              sides_ff, sides_in;
   logic [TICKET_WIDTH-1:0] tcount_ff, tcount_in;

   // scan pointer and step count
   logic [IDX_W-1:0]        scan_idx_ff;
   logic [CNT_W-1:0]        scan_cnt_ff;

   // result register
   logic                    rsp_valid_ff;
   logic [STATUS_WIDTH-1:0] status_ff;
   logic [TICKET_WIDTH-1:0] ticket_ff;
   logic [VALUE_WIDTH-1:0]  pvalue_ff;
   logic [OWNER_WIDTH-1:0]  powner_ff;
   logic                    pstats_ff;
   logic [TIME_WIDTH-1:0]   pwait_ff;
   logic                    notify_ff;

   logic [1:0]              side_flag;
   logic [IDX_W-1:0]        tail_prev;
   entry_type               wr_entry;

   assign side_flag = side_ff ? SIDE_RIGHT : SIDE_LEFT;
   assign tail_prev = ring_prev(tail_ff);
   assign rd_en     = cmd.rd_start | cmd.rd_next;
   assign rd_addr   = cmd.rd_start ? head_ff : scan_idx_ff;

   assign wr_entry.ticket = tcount_ff + 1'b1;
   assign wr_entry.value  = value_ff;
   assign wr_entry.owner  = owner_ff;
   assign wr_entry.stats  = stats_ff;
   assign wr_entry.stamp  = now_ff;

   // status back to the controller
   always_comb begin
      stat.func_cancel = (func_ff == FUNC_CANCEL);
      stat.side_ok     = |(sides_ff & side_flag);
      stat.full        = (count_ff != '0) && (tail_ff == head_ff);
      stat.hit         = live_ff[rd_idx_ff] && (rd_data_ff.ticket == cticket_ff);
      stat.scan_done   = (scan_cnt_ff == CNT_W'(QUEUE_DEPTH));
      stat.out_free    = !rsp_valid_ff || rsp_ready;
      stat.fix_done    = (count_ff == '0) || (live_ff[head_ff] && live_ff[tail_prev]);
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff    <= req_func;
         side_ff    <= req_side;
         value_ff   <= req_value;
         owner_ff   <= req_owner;
         stats_ff   <= req_with_stats;
         cticket_ff <= req_cancel_ticket;
         now_ff     <= req_now;
      end
   end

   // memory write at the tail, registered read
   always_ff @(posedge clock) begin
      if (cmd.enqueue) begin
         mem[tail_ff] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_idx_ff  <= rd_addr;
      end
   end

   // scan pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff <= '0;
         scan_idx_ff <= '0;
      end else if (rd_en) begin
         scan_idx_ff <= ring_next(rd_addr);
         scan_cnt_ff <= cmd.rd_start ? CNT_W'(1) : scan_cnt_ff + 1'b1;
      end
   end

   // ring bookkeeping
   always_comb begin
      live_in   = live_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      sides_in  = sides_ff;
      tcount_in = tcount_ff;
      if (cmd.enqueue) begin
         live_in[tail_ff] = 1'b1;
         tail_in          = ring_next(tail_ff);
         count_in         = count_ff + 1'b1;
         tcount_in        = tcount_ff + 1'b1;
         if (count_ff == '0) begin
            sides_in = side_flag;
         end
      end
      if (cmd.remove) begin
         live_in[rd_idx_ff] = 1'b0;
         count_in           = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            head_in  = '0;
            tail_in  = '0;
            sides_in = SIDE_BOTH;
         end
      end
      if (cmd.fix_step) begin
         if (!live_ff[head_ff]) begin
            head_in = ring_next(head_ff);
         end
         if (!live_ff[tail_prev]) begin
            tail_in = tail_prev;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff   <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         sides_ff  <= SIDE_BOTH;
         tcount_ff <= '0;
      end else begin
         live_ff   <= live_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         sides_ff  <= sides_in;
         tcount_ff <= tcount_in;
      end
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload, formed by kind
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         status_ff <= cmd.rsp_kind;
         ticket_ff <= '0;
         pvalue_ff <= '0;
         powner_ff <= '0;
         pstats_ff <= 1'b0;
         pwait_ff  <= '0;
         notify_ff <= 1'b0;
         case (cmd.rsp_kind)
            ST_QUEUED: begin
               ticket_ff <= tcount_ff;
            end
            ST_MATCHED: begin
               ticket_ff <= rd_data_ff.ticket;
               pvalue_ff <= rd_data_ff.value;
               powner_ff <= rd_data_ff.owner;
               pstats_ff <= rd_data_ff.stats;
               pwait_ff  <= now_ff - rd_data_ff.stamp;
            end
            ST_CANCELLED: begin
               ticket_ff <= cticket_ff;
               powner_ff <= rd_data_ff.owner;
               notify_ff <= (rd_data_ff.owner != owner_ff);
            end
            ST_TOO_LATE: begin
               ticket_ff <= cticket_ff;
            end
            default: begin
               ticket_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_ticket        = ticket_ff;
   assign rsp_partner_value = pvalue_ff;
   assign rsp_partner_owner = powner_ff;
   assign rsp_partner_stats = pstats_ff;
   assign rsp_partner_wait  = pwait_ff;
   assign rsp_notify_owner  = notify_ff;

endmodule

// ===== rtl/trq_ctrl.sv =====
// Controller of the rendezvous queue: sequences capture, enqueue, match,
// cancel scan, result load and ring repair. Depends on trq_pkg.
module trq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  trq_pkg::dp_stat_type stat,
   output trq_pkg::ctl_cmd_type cmd
);
   import trq_pkg::*;

   ctl_state_type state_ff, state_in;
   status_type    kind_ff, kind_in;

   // state and result kind registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= ST_QUEUED;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.rsp_kind = kind_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.func_cancel) begin
               cmd.rd_start = 1'b1;
               state_in     = S_SCAN;
            end else if (stat.side_ok) begin
               if (stat.full) begin
                  kind_in = ST_FULL;
               end else begin
                  cmd.enqueue = 1'b1;
                  kind_in     = ST_QUEUED;
               end
               state_in = S_RESULT;
            end else begin
               // other side: the head is the oldest live waiter
               cmd.rd_start = 1'b1;
               kind_in      = ST_MATCHED;
               state_in     = S_RESULT;
            end
         end
         S_SCAN: begin
            if (stat.hit) begin
               kind_in  = ST_CANCELLED;
               state_in = S_RESULT;
            end else if (stat.scan_done) begin
               kind_in  = ST_TOO_LATE;
               state_in = S_RESULT;
            end else begin
               cmd.rd_next = 1'b1;
            end
         end
         S_RESULT: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               if (kind_ff == ST_MATCHED || kind_ff == ST_CANCELLED) begin
                  state_in = S_REMOVE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_REMOVE: begin
            cmd.remove = 1'b1;
            state_in   = S_FIX;
         end
         S_FIX: begin
            if (stat.fix_done) begin
               state_in = S_IDLE;
            end else begin
               cmd.fix_step = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/two_sided_rendezvous_queue_top.sv =====
// Two-sided rendezvous queue, top level. A beat is captured, then dispatched: an ask
// from the waiting side (any side when empty) is queued or refused as full, one from
// the other side matches the head waiter, a cancel scans up to QUEUE_DEPTH entries
// from the head by the one-entry-a-cycle read. The result loads when the output is
// free; a match or cancel hit then drops the entry and repairs the ring over holes
// ahead of the next beat. Synchronous reset empties the queue at once; no clearing pass.
module two_sided_rendezvous_queue_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_func,
   input  logic                             req_side,
   input  logic [trq_pkg::VALUE_WIDTH-1:0]  req_value,
   input  logic [trq_pkg::OWNER_WIDTH-1:0]  req_owner,
   input  logic                             req_with_stats,
   input  logic [trq_pkg::TICKET_WIDTH-1:0] req_cancel_ticket,
   input  logic [trq_pkg::TIME_WIDTH-1:0]   req_now,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [trq_pkg::STATUS_WIDTH-1:0] rsp_status,
   output logic [trq_pkg::TICKET_WIDTH-1:0] rsp_ticket,
   output logic [trq_pkg::VALUE_WIDTH-1:0]  rsp_partner_value,
   output logic [trq_pkg::OWNER_WIDTH-1:0]  rsp_partner_owner,
   output logic                             rsp_partner_stats,
   output logic [trq_pkg::TIME_WIDTH-1:0]   rsp_partner_wait,
   output logic                             rsp_notify_owner
);
   import trq_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;

   trq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   trq_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_func          (req_func),
      .req_side          (req_side),
      .req_value         (req_value),
      .req_owner         (req_owner),
      .req_with_stats    (req_with_stats),
      .req_cancel_ticket (req_cancel_ticket),
      .req_now           (req_now),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_ticket        (rsp_ticket),
      .rsp_partner_value (rsp_partner_value),
      .rsp_partner_owner (rsp_partner_owner),
      .rsp_partner_stats (rsp_partner_stats),
      .rsp_partner_wait  (rsp_partner_wait),
      .rsp_notify_owner  (rsp_notify_owner)
   );

endmodule

// ===== tb/sv/trq_checker.sv =====
// Scoreboard for the two-sided rendezvous queue: watches both channels, predicts each result
// from its own copy of the waiter ring and compares every result beat field by field.
// Depends on trq_pkg for sizes, side flags, operation and status codes.
`timescale 1ns / 100ps

module trq_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic                             req_func,
   input  logic                             req_side,
   input  logic [trq_pkg::VALUE_WIDTH-1:0]  req_value,
   input  logic [trq_pkg::OWNER_WIDTH-1:0]  req_owner,
   input  logic                             req_with_stats,
   input  logic [trq_pkg::TICKET_WIDTH-1:0] req_cancel_ticket,
   input  logic [trq_pkg::TIME_WIDTH-1:0]   req_now,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [trq_pkg::STATUS_WIDTH-1:0] rsp_status,
   input  logic [trq_pkg::TICKET_WIDTH-1:0] rsp_ticket,
   input  logic [trq_pkg::VALUE_WIDTH-1:0]  rsp_partner_value,
   input  logic [trq_pkg::OWNER_WIDTH-1:0]  rsp_partner_owner,
   input  logic                             rsp_partner_stats,
   input  logic [trq_pkg::TIME_WIDTH-1:0]   rsp_partner_wait,
   input  logic                             rsp_notify_owner,
   output int                               fail_count,
   output int                               outstanding
);
   import trq_pkg::*;

   // one predicted result beat
   typedef struct packed {
      status_type              status;
      logic [TICKET_WIDTH-1:0] ticket;
      logic [VALUE_WIDTH-1:0]  partner_value;
      logic [OWNER_WIDTH-1:0]  partner_owner;
      logic                    partner_stats;
      logic [TIME_WIDTH-1:0]   partner_wait;
      logic                    notify_owner;
   } rdv_result_type;

   // shadow of the waiter ring
   logic                    w_live   [QUEUE_DEPTH];
   logic [TICKET_WIDTH-1:0] w_ticket [QUEUE_DEPTH];
   logic [VALUE_WIDTH-1:0]  w_value  [QUEUE_DEPTH];
   logic [OWNER_WIDTH-1:0]  w_owner  [QUEUE_DEPTH];
   logic                    w_stats  [QUEUE_DEPTH];
   logic [TIME_WIDTH-1:0]   w_stamp  [QUEUE_DEPTH];
   logic [IDX_W-1:0]        w_head;
   logic [IDX_W-1:0]        w_tail;
   int                      w_count;
   logic [1:0]              w_sides;
   logic [TICKET_WIDTH-1:0] w_last_ticket;

   rdv_result_type awaited_results[$];
   int             mismatches = 0;

   function automatic void clear_ring();
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         w_live[i]   = 1'b0;
         w_ticket[i] = '0;
         w_value[i]  = '0;
         w_owner[i]  = '0;
         w_stats[i]  = 1'b0;
         w_stamp[i]  = '0;
      end
      w_head        = '0;
      w_tail        = '0;
      w_count       = 0;
      w_sides       = SIDE_BOTH;
      w_last_ticket = '0;
   endfunction

   // free one slot; head skips holes forward, tail steps back over holes
   function automatic void drop_waiter(logic [IDX_W-1:0] idx);
      int               k;
      logic [IDX_W-1:0] prev;
      w_live[idx] = 1'b0;
      if (w_count > 0) w_count--;
      if (w_count == 0) begin
         w_head  = '0;
         w_tail  = '0;
         w_sides = SIDE_BOTH;
         return;
      end
      for (k = 0; k < QUEUE_DEPTH && !w_live[w_head]; k++) w_head = w_head + 1'b1;
      for (k = 0; k < QUEUE_DEPTH; k++) begin
         prev = w_tail - 1'b1;
         if (w_live[prev]) break;
         w_tail = prev;
      end
   endfunction

   // work out the result of one request beat and update the shadow ring
   function automatic rdv_result_type rendezvous_step(
      logic func, logic side, logic [VALUE_WIDTH-1:0] value,
      logic [OWNER_WIDTH-1:0] owner, logic stats,
      logic [TICKET_WIDTH-1:0] cticket, logic [TIME_WIDTH-1:0] now);
      rdv_result_type   r;
      logic [1:0]       side_flag;
      logic [IDX_W-1:0] idx;
      int               k;
      r = '0;
      side_flag = side ? SIDE_RIGHT : SIDE_LEFT;

      // cancel: oldest live waiter holding the ticket, else too late
      if (func == FUNC_CANCEL) begin
         r.ticket = cticket;
         for (k = 0; k < QUEUE_DEPTH; k++) begin
            idx = w_head + IDX_W'(k);
            if (w_live[idx] && w_ticket[idx] == cticket) begin
               r.status        = ST_CANCELLED;
               r.partner_owner = w_owner[idx];
               r.notify_owner  = (w_owner[idx] != owner);
               drop_waiter(idx);
               return r;
            end
         end
         r.status = ST_TOO_LATE;
         return r;
      end

      // ask from an accepted side: queue it unless the span is full
      if ((w_sides & side_flag) != 2'b00) begin
         if (w_count > 0 && w_tail == w_head) begin
            r.status = ST_FULL;
            return r;
         end
         w_last_ticket    = w_last_ticket + 1'b1;
         w_live[w_tail]   = 1'b1;
         w_ticket[w_tail] = w_last_ticket;
         w_value[w_tail]  = value;
         w_owner[w_tail]  = owner;
         w_stats[w_tail]  = stats;
         w_stamp[w_tail]  = now;
         w_tail           = w_tail + 1'b1;
         if (w_count == 0) w_sides = side_flag;
         w_count++;
         r.status = ST_QUEUED;
         r.ticket = w_last_ticket;
         return r;
      end

      // other side: pair with the oldest waiter, always at the head
      idx             = w_head;
      r.status        = ST_MATCHED;
      r.ticket        = w_ticket[idx];
      r.partner_value = w_value[idx];
      r.partner_owner = w_owner[idx];
      r.partner_stats = w_stats[idx];
      r.partner_wait  = now - w_stamp[idx];
      drop_waiter(idx);
      return r;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("rsp_%s mismatch: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // result beats are checked before the request beat of the same edge is predicted
   always @(posedge clock) begin
      rdv_result_type want;
      if (reset) begin
         clear_ring();
         awaited_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("unexpected result beat: status %0h ticket %0h", rsp_status, rsp_ticket);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("ticket", want.ticket, rsp_ticket);
               check_field("partner_value", want.partner_value, rsp_partner_value);
               check_field("partner_owner", want.partner_owner, rsp_partner_owner);
               check_field("partner_stats", want.partner_stats, rsp_partner_stats);
               check_field("partner_wait", want.partner_wait, rsp_partner_wait);
               check_field("notify_owner", want.notify_owner, rsp_notify_owner);
            end
         end
         if (req_valid && req_ready)
            awaited_results.push_back(rendezvous_step(req_func, req_side, req_value, req_owner,
                                                      req_with_stats, req_cancel_ticket,
                                                      req_now));
      end
      outstanding <= awaited_results.size();
      fail_count  <= mismatches;
   end

endmodule

// ===== tb/sv/tb_two_sided_rendezvous_queue_top.sv =====
// Testbench top for the two-sided rendezvous queue: clock, reset, request stimulus and
// result back-pressure, with the verdict. Depends on trq_pkg, the block and trq_checker.
`timescale 1ns / 100ps

module tb_two_sided_rendezvous_queue_top;
   import trq_pkg::*;

   localparam int RANDOM_ITEMS = 500;
   localparam int LONG_HOLD    = 400;

   typedef enum int {
      BURST_FILL,
      BURST_DRAIN,
      BURST_MIXED,
      BURST_NOISE
   } burst_kind_type;

   logic                    clock             = 1'b0;
   logic                    reset             = 1'b1;
   logic                    req_valid         = 1'b0;
   logic                    req_ready;
   logic                    req_func          = FUNC_ASK;
   logic                    req_side          = 1'b0;
   logic [VALUE_WIDTH-1:0]  req_value         = '0;
   logic [OWNER_WIDTH-1:0]  req_owner         = '0;
   logic                    req_with_stats    = 1'b0;
   logic [TICKET_WIDTH-1:0] req_cancel_ticket = '0;
   logic [TIME_WIDTH-1:0]   req_now           = '0;
   logic                    rsp_valid;
   logic                    rsp_ready         = 1'b0;
   logic [STATUS_WIDTH-1:0] rsp_status;
   logic [TICKET_WIDTH-1:0] rsp_ticket;
   logic [VALUE_WIDTH-1:0]  rsp_partner_value;
   logic [OWNER_WIDTH-1:0]  rsp_partner_owner;
   logic                    rsp_partner_stats;
   logic [TIME_WIDTH-1:0]   rsp_partner_wait;
   logic                    rsp_notify_owner;

   int fail_count;
   int outstanding;

   // stimulus knobs
   int                      idle_pct    = 0;
   int                      stall_pct   = 0;
   int                      n_random    = 0;
   int                      phase       = 0;
   logic                    lean_side   = 1'b0;
   logic [TIME_WIDTH-1:0]   clock_stamp = '0;
   logic [TICKET_WIDTH-1:0] last_ticket = '0;
   logic                    hold_go     = 1'b0;
   logic                    hold_done   = 1'b0;
   int                      hold_cnt    = 0;

   always #4 clock = ~clock;

   two_sided_rendezvous_queue_top dut (.*);

   trq_checker u_checker (.*);

   // most recent ticket handed out, so cancels can aim at live waiters
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready && rsp_status == ST_QUEUED) last_ticket <= rsp_ticket;
   end

   // receiver: one long hold-off counted here, otherwise random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_go && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_cnt = hold_cnt + 1;
         if (hold_cnt >= LONG_HOLD) hold_done = 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // offer one beat; valid stays high across back-to-back beats
   task automatic send_beat(logic func, logic side, logic [VALUE_WIDTH-1:0] value,
                            logic [OWNER_WIDTH-1:0] owner, logic stats,
                            logic [TICKET_WIDTH-1:0] cticket, logic [TIME_WIDTH-1:0] now);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= func;
      req_side          <= side;
      req_value         <= value;
      req_owner         <= owner;
      req_with_stats    <= stats;
      req_cancel_ticket <= cticket;
      req_now           <= now;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic ask(logic side, logic [VALUE_WIDTH-1:0] value, logic [OWNER_WIDTH-1:0] owner,
                      logic stats, logic [TIME_WIDTH-1:0] now);
      send_beat(FUNC_ASK, side, value, owner, stats, $urandom, now);
   endtask

   task automatic cancel(logic [TICKET_WIDTH-1:0] cticket, logic [OWNER_WIDTH-1:0] owner);
      send_beat(FUNC_CANCEL, 1'($urandom_range(0, 1)), {$urandom, $urandom}, owner,
                1'($urandom_range(0, 1)), cticket, clock_stamp);
   endtask

   // sender pause until every result beat has come back
   task automatic drain_wait();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // one random beat shaped by the burst kind
   task automatic send_random(burst_kind_type kind);
      int                      cancel_pct;
      int                      new_phase;
      logic                    func;
      logic                    side;
      logic [VALUE_WIDTH-1:0]  value;
      logic [OWNER_WIDTH-1:0]  owner;
      logic [TICKET_WIDTH-1:0] cticket;
      new_phase = n_random * 4 / RANDOM_ITEMS;
      if (new_phase != phase) begin
         phase = new_phase;
         drain_wait();
         case (phase)
            1: begin idle_pct = 68; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 68; end
            default: begin idle_pct = 7; stall_pct = 7; end
         endcase
      end
      case (kind)
         BURST_FILL:  begin cancel_pct = 10; side = ($urandom_range(0, 19) == 0) ^ lean_side; end
         BURST_DRAIN: begin cancel_pct = 10; side = ($urandom_range(0, 19) != 0) ^ lean_side; end
         BURST_MIXED: begin cancel_pct = 30; side = 1'($urandom_range(0, 1)); end
         default:     begin cancel_pct = 50; side = 1'($urandom_range(0, 1)); end
      endcase
      func = ($urandom_range(0, 99) < cancel_pct) ? FUNC_CANCEL : FUNC_ASK;
      case ($urandom_range(0, 9))
         0:       value = '0;
         1:       value = '1;
         default: value = {$urandom, $urandom};
      endcase
      owner = ($urandom_range(0, 1) != 0) ? OWNER_WIDTH'($urandom_range(0, 3))
                                          : OWNER_WIDTH'($urandom);
      // cancels mostly aim at recent tickets; noise also throws wild ones
      case ($urandom_range(0, 9))
         0:       cticket = (kind == BURST_NOISE) ? $urandom : '1;
         1:       cticket = '0;
         default: cticket = last_ticket - TICKET_WIDTH'($urandom_range(0, 12));
      endcase
      if ($urandom_range(0, 19) == 0) clock_stamp = {16'($urandom), $urandom};
      else clock_stamp = clock_stamp + TIME_WIDTH'($urandom_range(0, 1000));
      send_beat(func, side, value, owner, 1'($urandom_range(0, 1)), cticket, clock_stamp);
      n_random++;
   endtask

   task automatic run_burst(burst_kind_type kind, int len);
      for (int i = 0; i < len && n_random < RANDOM_ITEMS; i++) send_random(kind);
   endtask

   initial begin
      burst_kind_type kind;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, match with time wrap, cancels at middle and tail
      ask(1'b0, '0, '0, 1'b0, '0);                               // queued, ticket 1
      ask(1'b0, '1, '1, 1'b1, '1);                               // queued, ticket 2
      ask(1'b1, 64'h0123_4567_89ab_cdef, 16'h1234, 1'b0, 48'd5); // matches ticket 1
      ask(1'b1, 64'h5a5a_5a5a_a5a5_a5a5, 16'h0001, 1'b1, '0);    // matches 2, wait wraps
      cancel(32'd2, 16'h0001);                                   // too late
      ask(1'b1, 64'd33, 16'h0033, 1'b1, 48'd100);                // ticket 3
      ask(1'b1, 64'd44, 16'h0044, 1'b0, 48'd110);                // ticket 4
      ask(1'b1, 64'd55, 16'h0055, 1'b1, 48'd120);                // ticket 5
      cancel(32'd4, 16'h0044);                                   // hole mid-ring, same owner
      cancel(32'd3, 16'hbeef);                                   // head skips hole, notify
      cancel('1, '1);
      cancel('0, '0);
      ask(1'b0, 64'd66, 16'h0066, 1'b0, 48'd200);                // matches 5, queue empty
      ask(1'b1, 64'd77, 16'h0077, 1'b0, 48'd300);                // ticket 6
      ask(1'b1, 64'd88, 16'h0088, 1'b1, 48'd310);                // ticket 7
      ask(1'b1, 64'd99, 16'h0099, 1'b0, 48'd320);                // ticket 8
      cancel(32'd8, 16'h0000);                                   // tail steps back
      cancel(32'd7, 16'h0088);
      ask(1'b0, 64'd11, 16'h0011, 1'b1, 48'd400);                // matches 6
      clock_stamp = 48'd1000;
      drain_wait();

      // long receiver hold-off while one side keeps asking: ring fills, input stalls
      hold_go <= 1'b1;
      run_burst(BURST_FILL, 140);
      drain_wait();

      // random bursts that fill, drain and stir the ring
      while (n_random < RANDOM_ITEMS) begin
         kind = burst_kind_type'($urandom_range(0, 3));
         if ($urandom_range(0, 1) != 0) lean_side = ~lean_side;
         run_burst(kind, $urandom_range(8, 70));
      end

      drain_wait();
      repeat (150) @(posedge clock);
      if (fail_count == 0)
         $display("PASS two_sided_rendezvous_queue_top");
      else
         $display("FAIL two_sided_rendezvous_queue_top");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("FAIL two_sided_rendezvous_queue_top");
      $finish;
   end

endmodule
